// ===== hw/rtl/link_setup_frame_handshake_unit_defines.svh =====
// Assertion macros shared by the link setup handshake RTL.
// No dependencies; included by the files that carry assertions.
`ifndef LINK_SETUP_FRAME_HANDSHAKE_UNIT_DEFINES_SVH
`define LINK_SETUP_FRAME_HANDSHAKE_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define LSFH_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("link setup handshake assertion failed");
`define LSFH_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("link setup handshake assertion failed");
`else
`define LSFH_ASSERT(name, clk, rst_n, prop)
`define LSFH_ASSERT_ALWAYS(name, clk, prop)
`endif
`endif

// ===== hw/rtl/lsfh_pkg.sv =====
// Types, codes and the frame matcher step of the link setup handshake.
// No dependencies; imported by every module of the block.
package lsfh_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QCNT_W      = 2;
  localparam int unsigned BEAT_W      = 3;
  localparam logic [BEAT_W-1:0] LAST_BEAT = 3'd4;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_TICK  = 2'd1,
    KIND_START = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    M_START = 3'd0,
    M_FLAG  = 3'd1,
    M_ADDR  = 3'd2,
    M_CTRL  = 3'd3,
    M_CHECK = 3'd4
  } match_e;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_WAIT = 2'd1,
    PH_CONN = 2'd2,
    PH_FAIL = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    CFG_ROLE        = 3'd0,
    CFG_FLAG        = 3'd1,
    CFG_CMD_ADDR    = 3'd2,
    CFG_REPLY_ADDR  = 3'd3,
    CFG_SEND_CTRL   = 3'd4,
    CFG_EXPECT_CTRL = 3'd5,
    CFG_TIMEOUT     = 3'd6,
    CFG_MAX_TRIES   = 3'd7
  } cfg_index_e;

  typedef struct packed {
    logic       role_is_receiver;
    logic [7:0] flag_value;
    logic [7:0] command_address;
    logic [7:0] reply_address;
    logic [7:0] send_control;
    logic [7:0] expect_control;
    logic [7:0] timeout_ticks;
    logic [3:0] max_tries;
  } cfg_t;

  // One queued job: either a whole frame to send or a single status word.
  typedef struct packed {
    logic       is_frame;
    logic [7:0] flag;
    logic [7:0] addr;
    logic [7:0] ctrl;
    phase_e     status;
  } job_t;

  typedef struct packed {
    match_e next;
    logic   hit;
  } match_res_t;

  function automatic match_res_t match_step(match_e cur, logic [7:0] b,
                                            logic [7:0] addr, logic [7:0] ctrl,
                                            logic [7:0] fl);
    match_res_t r;
    r.hit  = 1'b0;
    r.next = M_START;
    unique case (cur)
      M_FLAG: begin
        if (b == addr) r.next = M_ADDR;
        else if (b == fl) r.next = M_FLAG;
      end
      M_ADDR: begin
        if (b == ctrl) r.next = M_CTRL;
        else if (b == fl) r.next = M_FLAG;
      end
      M_CTRL: begin
        if (b == (addr ^ ctrl)) r.next = M_CHECK;
        else if (b == fl) r.next = M_FLAG;
      end
      M_CHECK: begin
        r.hit = (b == fl);
      end
      default: begin
        // Start and the unused codes look for an opening flag.
        if (b == fl) r.next = M_FLAG;
      end
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/lsfh_front.sv =====
// Front end: accepts input words, runs matcher, phase, retry and timer state,
// and posts one job per word to the queue. Depends on lsfh_pkg.
`include "link_setup_frame_handshake_unit_defines.svh"
module lsfh_front import lsfh_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       in_valid_i,
  input  logic [1:0] in_kind_i,
  input  logic [7:0] in_byte_i,
  input  logic       queue_full_i,
  output logic       in_ready_o,
  output logic       push_o,
  output job_t       job_o
);

  match_e     match_q, match_d;
  phase_e     phase_q, phase_d;
  logic [3:0] tries_q, tries_d;
  logic [7:0] timer_q, timer_d;
  logic       accept;
  logic [7:0] load_val;
  logic [7:0] match_addr;
  match_res_t mres;

  assign in_ready_o = !queue_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept;
  assign load_val   = (cfg_i.timeout_ticks != 8'd0) ? cfg_i.timeout_ticks : 8'd1;
  assign match_addr = cfg_i.role_is_receiver ? cfg_i.command_address : cfg_i.reply_address;
  assign mres       = match_step(match_q, in_byte_i, match_addr, cfg_i.expect_control,
                                 cfg_i.flag_value);

  always_comb begin
    match_d = match_q;
    phase_d = phase_q;
    tries_d = tries_q;
    timer_d = timer_q;
    job_o.is_frame = 1'b0;
    job_o.flag     = cfg_i.flag_value;
    job_o.addr     = cfg_i.command_address;
    job_o.ctrl     = cfg_i.send_control;
    unique case (kind_e'(in_kind_i))
      KIND_START: begin
        match_d = M_START;
        phase_d = PH_WAIT;
        if (!cfg_i.role_is_receiver) begin
          tries_d = (cfg_i.max_tries != 4'd0) ? cfg_i.max_tries - 4'd1 : 4'd0;
          timer_d = load_val;
          job_o.is_frame = 1'b1;
        end
      end
      KIND_BYTE: begin
        if (cfg_i.role_is_receiver) begin
          match_d = mres.next;
          if (mres.hit) begin
            phase_d = PH_CONN;
            job_o.is_frame = 1'b1;
            job_o.addr     = cfg_i.reply_address;
          end
        end else if (phase_q == PH_WAIT) begin
          match_d = mres.next;
          if (mres.hit) begin
            phase_d = PH_CONN;
            timer_d = 8'd0;
          end
        end
      end
      KIND_TICK: begin
        if (!cfg_i.role_is_receiver && phase_q == PH_WAIT) begin
          priority if (timer_q > 8'd1) begin
            timer_d = timer_q - 8'd1;
          end else if (tries_q != 4'd0) begin
            tries_d = tries_q - 4'd1;
            timer_d = load_val;
            match_d = M_START;
            job_o.is_frame = 1'b1;
          end else begin
            timer_d = 8'd0;
            phase_d = PH_FAIL;
          end
        end
      end
      default: begin
      end
    endcase
    job_o.status = phase_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= M_START;
      phase_q <= PH_IDLE;
      tries_q <= 4'd0;
      timer_q <= 8'd0;
    end else if (accept) begin
      match_q <= match_d;
      phase_q <= phase_d;
      tries_q <= tries_d;
      timer_q <= timer_d;
    end
  end

  `LSFH_ASSERT(a_start_enters_wait, clk_i, rst_ni,
    (accept && in_kind_i == KIND_START) |=> (phase_q == PH_WAIT))
  `LSFH_ASSERT(a_tick_counts_down, clk_i, rst_ni,
    (accept && in_kind_i == KIND_TICK && !cfg_i.role_is_receiver && phase_q == PH_WAIT
     && timer_q > 8'd1) |=> (timer_q == $past(timer_q) - 8'd1))

endmodule

// ===== hw/rtl/lsfh_queue.sv =====
// Two-entry job queue between front and back; head entry is read in place.
// Depends on lsfh_pkg.
`include "link_setup_frame_handshake_unit_defines.svh"
module lsfh_queue import lsfh_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_job_i,
  input  logic pop_i,
  output logic full_o,
  output logic empty_o,
  output job_t head_o
);

  job_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = do_push ? wr_q + 1'b1 : wr_q;
    rd_d  = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + QCNT_W'(do_push) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_job_i;
    end
  end

  `LSFH_ASSERT(a_count_bounded, clk_i, rst_ni, cnt_q <= QCNT_W'(QUEUE_DEPTH))

endmodule

// ===== hw/rtl/lsfh_back.sv =====
// Back end: turns the head job into one status word or five frame bytes.
// Depends on lsfh_pkg.
`include "link_setup_frame_handshake_unit_defines.svh"
module lsfh_back import lsfh_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       have_job_i,
  input  job_t       job_i,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  output logic [7:0] out_byte_o,
  output logic       out_tx_valid_o,
  output logic       out_last_o,
  output logic [1:0] out_status_o,
  output logic       pop_o
);

  logic [BEAT_W-1:0] beat_q, beat_d;
  logic              fire;

  assign out_valid_o    = have_job_i;
  assign fire           = out_valid_o && out_ready_i;
  assign out_tx_valid_o = job_i.is_frame;
  assign out_last_o     = !job_i.is_frame || (beat_q == LAST_BEAT);
  assign out_status_o   = job_i.status;
  assign pop_o          = fire && out_last_o;

  always_comb begin
    out_byte_o = 8'd0;
    if (job_i.is_frame) begin
      unique case (beat_q)
        3'd1:    out_byte_o = job_i.addr;
        3'd2:    out_byte_o = job_i.ctrl;
        3'd3:    out_byte_o = job_i.addr ^ job_i.ctrl;
        default: out_byte_o = job_i.flag;
      endcase
    end
  end

  always_comb begin
    beat_d = beat_q;
    if (fire) begin
      beat_d = out_last_o ? '0 : beat_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q <= '0;
    end else begin
      beat_q <= beat_d;
    end
  end

  // A frame in progress keeps its job at the queue head until the last byte.
  `LSFH_ASSERT(a_beat_in_frame, clk_i, rst_ni,
    (beat_q != '0) |-> (have_job_i && job_i.is_frame && beat_q <= LAST_BEAT))

endmodule

// ===== hw/rtl/link_setup_frame_handshake_unit.sv =====
// Link setup handshake on five-byte supervision frames.
// Each accepted item is written into the job queue, and its first result word is offered from the queue head.
// Throughput: one item per cycle for status-only items and one byte per cycle from the back-end
// serializer while the output is not stalled; the two-entry queue keeps input open until it fills.
// Reset: asynchronous; clears matcher, phase, tries, timer and queue, and loads the
// configuration defaults. No clearing pass is needed.
module link_setup_frame_handshake_unit import lsfh_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [2:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
  input  logic [1:0] s_axis_tuser,   // [1:0] kind
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] tx_byte
  output logic [2:0] m_axis_tuser,   // [0] tx_valid, [2:1] link_status
  output logic       m_axis_tlast
);

  cfg_t cfg_q;
  logic push, pop, full, empty;
  job_t push_job, head_job;
  logic tx_valid;
  logic [1:0] status;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.role_is_receiver <= 1'b0;
      cfg_q.flag_value       <= 8'd126;
      cfg_q.command_address  <= 8'd3;
      cfg_q.reply_address    <= 8'd1;
      cfg_q.send_control     <= 8'd3;
      cfg_q.expect_control   <= 8'd7;
      cfg_q.timeout_ticks    <= 8'd3;
      cfg_q.max_tries        <= 4'd3;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_ROLE:        cfg_q.role_is_receiver <= cfg_data_i[0];
        CFG_FLAG:        cfg_q.flag_value       <= cfg_data_i;
        CFG_CMD_ADDR:    cfg_q.command_address  <= cfg_data_i;
        CFG_REPLY_ADDR:  cfg_q.reply_address    <= cfg_data_i;
        CFG_SEND_CTRL:   cfg_q.send_control     <= cfg_data_i;
        CFG_EXPECT_CTRL: cfg_q.expect_control   <= cfg_data_i;
        CFG_TIMEOUT:     cfg_q.timeout_ticks    <= cfg_data_i;
        CFG_MAX_TRIES:   cfg_q.max_tries        <= cfg_data_i[3:0];
        default: begin
        end
      endcase
    end
  end

  lsfh_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (s_axis_tvalid),
    .in_kind_i    (s_axis_tuser),
    .in_byte_i    (s_axis_tdata),
    .queue_full_i (full),
    .in_ready_o   (s_axis_tready),
    .push_o       (push),
    .job_o        (push_job)
  );

  lsfh_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .pop_i      (pop),
    .full_o     (full),
    .empty_o    (empty),
    .head_o     (head_job)
  );

  lsfh_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .have_job_i     (!empty),
    .job_i          (head_job),
    .out_ready_i    (m_axis_tready),
    .out_valid_o    (m_axis_tvalid),
    .out_byte_o     (m_axis_tdata),
    .out_tx_valid_o (tx_valid),
    .out_last_o     (m_axis_tlast),
    .out_status_o   (status),
    .pop_o          (pop)
  );

  assign m_axis_tuser = {status, tx_valid};

endmodule

// ===== verif/lsfh_frame_checker.sv =====
// Checker for the link setup handshake: mirrors the register writes, predicts the
// words that each accepted input word causes and compares them in order.
// Depends on lsfh_pkg for the kind, phase, matcher and register codes.
module lsfh_frame_checker import lsfh_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  input  logic       cfg_ready_i,
  input  logic [2:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [7:0] in_data_i,   // [7:0] rx_byte
  input  logic [1:0] in_user_i,   // [1:0] kind
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic [7:0] out_data_i,  // [7:0] tx_byte
  input  logic [2:0] out_user_i,  // [0] tx_valid, [2:1] link_status
  input  logic       out_last_i,
  output int         fail_count_o,
  output int         words_due_o
);

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       last;
    phase_e     status;
  } tx_word_t;

  cfg_t       link_cfg;
  match_e     match_pos;
  phase_e     link_phase;
  logic [3:0] tries_left;
  logic [7:0] ticks_left;
  tx_word_t   tx_words_due[$];
  tx_word_t   seen_word;
  tx_word_t   want_word;
  int         miss_count;

  function automatic logic [7:0] ticks_to_load();
    return (link_cfg.timeout_ticks != 8'd0) ? link_cfg.timeout_ticks : 8'd1;
  endfunction

  // Advances the frame matcher by one byte and reports a completed frame.
  function automatic logic frame_matched(input logic [7:0] b, input logic [7:0] addr,
                                         input logic [7:0] ctrl);
    logic       hit;
    logic [7:0] fl;
    hit = 1'b0;
    fl  = link_cfg.flag_value;
    case (match_pos)
      M_FLAG:  match_pos = (b == addr) ? M_ADDR : (b == fl) ? M_FLAG : M_START;
      M_ADDR:  match_pos = (b == ctrl) ? M_CTRL : (b == fl) ? M_FLAG : M_START;
      M_CTRL:  match_pos = (b == (addr ^ ctrl)) ? M_CHECK : (b == fl) ? M_FLAG : M_START;
      M_CHECK: begin
        hit       = (b == fl);
        match_pos = M_START;
      end
      default: match_pos = (b == fl) ? M_FLAG : M_START;
    endcase
    return hit;
  endfunction

  task automatic queue_frame_words(input logic [7:0] addr);
    logic [7:0] frame_bytes [5];
    frame_bytes = '{link_cfg.flag_value, addr, link_cfg.send_control,
                    addr ^ link_cfg.send_control, link_cfg.flag_value};
    for (int k = 0; k < 5; k++) begin
      tx_words_due.push_back('{tx_valid: 1'b1, tx_byte: frame_bytes[k],
                               last: (k == 4), status: link_phase});
    end
  endtask

  task automatic queue_status_word();
    tx_words_due.push_back('{tx_valid: 1'b0, tx_byte: 8'd0, last: 1'b1, status: link_phase});
  endtask

  task automatic predict_link_response(input logic [1:0] kind, input logic [7:0] rx);
    logic resent;
    resent = 1'b0;
    case (kind)
      KIND_START: begin
        match_pos  = M_START;
        link_phase = PH_WAIT;
        if (link_cfg.role_is_receiver) begin
          queue_status_word();
        end else begin
          tries_left = (link_cfg.max_tries != 4'd0) ? link_cfg.max_tries - 4'd1 : 4'd0;
          ticks_left = ticks_to_load();
          queue_frame_words(link_cfg.command_address);
        end
      end
      KIND_BYTE: begin
        if (link_cfg.role_is_receiver) begin
          if (frame_matched(rx, link_cfg.command_address, link_cfg.expect_control)) begin
            link_phase = PH_CONN;
            queue_frame_words(link_cfg.reply_address);
          end else begin
            queue_status_word();
          end
        end else begin
          // A transmitter only listens while it waits for the reply.
          if (link_phase == PH_WAIT) begin
            if (frame_matched(rx, link_cfg.reply_address, link_cfg.expect_control)) begin
              link_phase = PH_CONN;
              ticks_left = 8'd0;
            end
          end
          queue_status_word();
        end
      end
      KIND_TICK: begin
        if (!link_cfg.role_is_receiver && link_phase == PH_WAIT) begin
          if (ticks_left > 8'd1) begin
            ticks_left = ticks_left - 8'd1;
          end else if (tries_left != 4'd0) begin
            tries_left = tries_left - 4'd1;
            ticks_left = ticks_to_load();
            match_pos  = M_START;
            resent     = 1'b1;
            queue_frame_words(link_cfg.command_address);
          end else begin
            ticks_left = 8'd0;
            link_phase = PH_FAIL;
          end
        end
        if (!resent) queue_status_word();
      end
      default: queue_status_word();
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_cfg.role_is_receiver = 1'b0;
      link_cfg.flag_value       = 8'd126;
      link_cfg.command_address  = 8'd3;
      link_cfg.reply_address    = 8'd1;
      link_cfg.send_control     = 8'd3;
      link_cfg.expect_control   = 8'd7;
      link_cfg.timeout_ticks    = 8'd3;
      link_cfg.max_tries        = 4'd3;
      match_pos  = M_START;
      link_phase = PH_IDLE;
      tries_left = 4'd0;
      ticks_left = 8'd0;
      tx_words_due.delete();
      miss_count = 0;
      fail_count_o <= 0;
      words_due_o  <= 0;
    end else begin
      // Output words always lag their input word, so they are checked first.
      if (out_valid_i && out_ready_i) begin
        seen_word = '{tx_valid: out_user_i[0], tx_byte: out_data_i, last: out_last_i,
                      status: phase_e'(out_user_i[2:1])};
        if (tx_words_due.size() == 0) begin
          $error("output word with no expectation: tx_byte %0d", out_data_i);
          miss_count++;
        end else begin
          want_word = tx_words_due.pop_front();
          if (seen_word.tx_valid !== want_word.tx_valid) begin
            $error("tx_valid: expected %0d, actual %0d", want_word.tx_valid,
                   seen_word.tx_valid);
            miss_count++;
          end
          if (seen_word.tx_byte !== want_word.tx_byte) begin
            $error("tx_byte: expected %0d, actual %0d", want_word.tx_byte,
                   seen_word.tx_byte);
            miss_count++;
          end
          if (seen_word.last !== want_word.last) begin
            $error("last: expected %0d, actual %0d", want_word.last, seen_word.last);
            miss_count++;
          end
          if (seen_word.status !== want_word.status) begin
            $error("link_status: expected %0d, actual %0d", want_word.status,
                   seen_word.status);
            miss_count++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_ROLE:        link_cfg.role_is_receiver = cfg_data_i[0];
          CFG_FLAG:        link_cfg.flag_value       = cfg_data_i;
          CFG_CMD_ADDR:    link_cfg.command_address  = cfg_data_i;
          CFG_REPLY_ADDR:  link_cfg.reply_address    = cfg_data_i;
          CFG_SEND_CTRL:   link_cfg.send_control     = cfg_data_i;
          CFG_EXPECT_CTRL: link_cfg.expect_control   = cfg_data_i;
          CFG_TIMEOUT:     link_cfg.timeout_ticks    = cfg_data_i;
          CFG_MAX_TRIES:   link_cfg.max_tries        = cfg_data_i[3:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) predict_link_response(in_user_i, in_data_i);
      words_due_o  <= tx_words_due.size();
      fail_count_o <= miss_count;
    end
  end

endmodule

// ===== verif/tb_link_setup_frame_handshake_unit.sv =====
// Testbench top for the link setup handshake: drives register writes and input
// words with random stalls on both sides, and gives the verdict.
// Depends on lsfh_pkg, the block itself and lsfh_frame_checker.
module tb_link_setup_frame_handshake_unit;
  import lsfh_pkg::*;

  localparam int         CLK_PERIOD  = 8;
  localparam int         LONG_HOLD   = 100;
  localparam int         DRAIN_PAD   = 8;
  localparam int         RUN_LIMIT   = 2_000_000;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       cfg_valid_i   = 1'b0;
  logic [2:0] cfg_index_i   = '0;
  logic [7:0] cfg_data_i    = '0;
  logic       cfg_ready_o;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = '0;
  logic [1:0] s_axis_tuser  = '0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic [2:0] m_axis_tuser;
  logic       m_axis_tlast;
  int         fail_count;
  int         words_due;

  // Stimulus side copy of the frame bytes currently programmed.
  logic       role_rx  = 1'b0;
  logic [7:0] flag_b   = 8'd126;
  logic [7:0] cmd_addr = 8'd3;
  logic [7:0] rep_addr = 8'd1;
  logic [7:0] exp_ctrl = 8'd7;

  bit sender_gaps  = 1'b0;
  bit calm         = 1'b0;
  bit hold_request = 1'b0;
  int hold_left    = 0;
  int stall_left   = 0;
  int items_sent   = 0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  link_setup_frame_handshake_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  lsfh_frame_checker frame_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_i  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .out_valid_i (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_i  (m_axis_tdata),
    .out_user_i  (m_axis_tuser),
    .out_last_i  (m_axis_tlast),
    .fail_count_o(fail_count),
    .words_due_o (words_due)
  );

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (calm) begin
        m_axis_tready <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 7);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Timeouts and try budgets: zero, all ones, or a small count.
  function automatic logic [7:0] pick_count();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(1, 4));
    endcase
  endfunction

  task automatic write_reg(input cfg_index_e idx, input logic [7:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apply_setup(input logic rx, input logic [7:0] fl, input logic [7:0] ca,
                             input logic [7:0] ra, input logic [7:0] sc,
                             input logic [7:0] ec, input logic [7:0] tm,
                             input logic [7:0] mt);
    write_reg(CFG_ROLE, {7'd0, rx});
    write_reg(CFG_FLAG, fl);
    write_reg(CFG_CMD_ADDR, ca);
    write_reg(CFG_REPLY_ADDR, ra);
    write_reg(CFG_SEND_CTRL, sc);
    write_reg(CFG_EXPECT_CTRL, ec);
    write_reg(CFG_TIMEOUT, tm);
    write_reg(CFG_MAX_TRIES, mt);
    role_rx  = rx;
    flag_b   = fl;
    cmd_addr = ca;
    rep_addr = ra;
    exp_ctrl = ec;
  endtask

  task automatic offer_item(input logic [1:0] kind, input logic [7:0] b);
    if (sender_gaps && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  // Sends one frame byte by byte; when spoiled, one byte is replaced at random.
  task automatic offer_frame(input logic [7:0] addr, input logic [7:0] ctrl,
                             input bit spoil);
    logic [7:0] frame_bytes [5];
    int         bad_pos;
    frame_bytes = '{flag_b, addr, ctrl, addr ^ ctrl, flag_b};
    bad_pos     = spoil ? int'($urandom_range(0, 4)) : -1;
    for (int k = 0; k < 5; k++) begin
      offer_item(KIND_BYTE, (k == bad_pos) ? 8'($urandom_range(0, 255)) : frame_bytes[k]);
    end
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (words_due != 0) @(posedge clk_i);
    repeat (DRAIN_PAD) @(posedge clk_i);
  endtask

  initial begin
    int   goal;
    logic rx_role;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Transmitter with the reset settings.
    offer_item(KIND_UNUSED, 8'hFF);
    offer_item(KIND_TICK, 8'h00);        // tick while idle is ignored
    offer_item(KIND_BYTE, 8'h00);        // byte outside waiting is ignored
    offer_item(KIND_START, 8'h5A);
    offer_item(KIND_BYTE, flag_b);       // repeated opening flag
    offer_frame(rep_addr, exp_ctrl, 1'b0);
    offer_item(KIND_START, 8'hA5);       // restart while connected
    offer_item(KIND_BYTE, flag_b);
    offer_item(KIND_BYTE, rep_addr);
    offer_item(KIND_BYTE, flag_b);       // flag in the address state
    offer_item(KIND_BYTE, rep_addr);
    offer_item(KIND_BYTE, ~exp_ctrl);    // mismatch drops back to start
    repeat (3) offer_item(KIND_TICK, 8'h00);
    settle();

    // Zero timeout and zero tries both act as one: the first tick fails the link.
    apply_setup(1'b0, 8'd126, 8'd3, 8'd1, 8'd3, 8'd7, 8'd0, 8'd0);
    offer_item(KIND_START, 8'h00);
    offer_item(KIND_TICK, 8'hFF);
    settle();

    // Receiver at the byte extremes.
    apply_setup(1'b1, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h0F);
    offer_item(KIND_START, 8'h00);
    offer_item(KIND_TICK, 8'h00);
    offer_frame(cmd_addr, exp_ctrl, 1'b0);
    settle();

    // The receiver holds off while starts keep coming, so the input backs up.
    apply_setup(1'b0, 8'd126, 8'd3, 8'd1, 8'd3, 8'd7, 8'd2, 8'd2);
    hold_request = 1'b1;
    repeat (8) offer_item(KIND_START, 8'($urandom_range(0, 255)));
    repeat (4) offer_item(KIND_TICK, 8'h00);
    settle();

    for (int ph = 0; ph < 5; ph++) begin
      rx_role = (ph < 2) ? ph[0] : 1'($urandom_range(0, 1));
      apply_setup(rx_role, pick_byte(), pick_byte(), pick_byte(), pick_byte(),
                  pick_byte(), pick_count(), pick_count());
      sender_gaps = (ph != 4);
      calm        = (ph == 4);
      goal        = items_sent + 12;
      while (items_sent < goal) begin
        case ($urandom_range(0, 9))
          0, 1: offer_item(KIND_START, 8'($urandom_range(0, 255)));
          2, 3, 4, 5: begin
            if ($urandom_range(0, 3) == 0) offer_item(KIND_BYTE, flag_b);
            offer_frame(role_rx ? cmd_addr : rep_addr, exp_ctrl, 1'b0);
          end
          6, 7: repeat ($urandom_range(1, 5)) offer_item(KIND_TICK, 8'($urandom_range(0, 255)));
          8: offer_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
          default: offer_frame(role_rx ? cmd_addr : rep_addr, exp_ctrl, 1'b1);
        endcase
      end
      settle();
    end

    if (fail_count == 0) begin
      $display("tb_link_setup_frame_handshake_unit OK");
    end else begin
      $display("tb_link_setup_frame_handshake_unit NOT OK");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT);
    $display("tb_link_setup_frame_handshake_unit NOT OK");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/lsfh_pkg.sv
hw/rtl/lsfh_front.sv
hw/rtl/lsfh_queue.sv
hw/rtl/lsfh_back.sv
hw/rtl/link_setup_frame_handshake_unit.sv
verif/lsfh_frame_checker.sv
verif/tb_link_setup_frame_handshake_unit.sv
